>>> sv/integer_to_base_digits_defines.svh
// ----------------------------------------------------------------------------
// Integer to base digits: assertion macros
// Shared assertion macros; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_BASE_DIGITS_DEFINES_SVH
`define INTEGER_TO_BASE_DIGITS_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define ITBD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("integer_to_base_digits: assertion failed");

// Property checked on every clock edge, reset included.
`define ITBD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("integer_to_base_digits: assertion failed");

`else

`define ITBD_ASSERT(lbl, clk, rst_n, prop)
`define ITBD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> sv/itbd_pkg.sv
// ----------------------------------------------------------------------------
// Integer to base digits: package
// Shared constants, types and the digit to ASCII mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package itbd_pkg;

    // Default sizes.
    localparam int VALUE_WIDTH_DEF = 31;
    localparam int MAX_DIGITS_DEF  = 32;

    // Field widths fixed by the interface.
    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 7;
    localparam int APB_DW    = 32;
    localparam int PADDR_W   = 3;

    // Radix register.
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    // Register index, taken from the word address bit.
    localparam logic REG_RADIX = 1'b0;

    // ASCII codes and digit thresholds.
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 7'd65;
    localparam logic [RADIX_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;

    // Quotient bits resolved per divider cycle.
    localparam int DIV_BITS_PER_CYCLE = 8;

    // Depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_back_state;

    // Status of the back end seen by the top level.
    typedef struct packed {
        logic idle;
        logic emitting;
    } t_back_status;

    // Clamp the programmed radix into the range two to thirty-six.
    function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    // Map a digit value to '0'..'9' or 'A'..'Z'.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d <= DIGIT_NINE) begin
            res = CHAR_ZERO + CHAR_W'(d);
        end else begin
            res = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/itbd_in_if.sv
// ----------------------------------------------------------------------------
// Integer to base digits: input channel
// Valid/ready channel carrying the value to convert.
// ----------------------------------------------------------------------------
`default_nettype none

interface itbd_in_if #(
    parameter int VALUE_WIDTH = itbd_pkg::VALUE_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> sv/itbd_out_if.sv
// ----------------------------------------------------------------------------
// Integer to base digits: output channel
// Valid/ready channel carrying one ASCII digit and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface itbd_out_if ();
    logic                          valid;
    logic                          ready;
    logic [itbd_pkg::CHAR_W-1:0]   digit_char;
    logic                          last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

>>> sv/itbd_front.sv
// ----------------------------------------------------------------------------
// Integer to base digits: front end
// Holds the radix register, accepts values and pushes them with their
// clamped radix into the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module itbd_front #(
    parameter int VALUE_WIDTH = itbd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    itbd_in_if.sink                              i_in_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [itbd_pkg::PADDR_W-1:0]         paddr,
    input  logic [itbd_pkg::APB_DW-1:0]          pwdata,
    output logic [itbd_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output logic [VALUE_WIDTH-1:0]               o_push_value,
    output logic [itbd_pkg::RADIX_W-1:0]         o_push_radix
);

    logic [itbd_pkg::RADIX_W-1:0] r_radix;
    logic                         reg_hit;

    // Register decode on the word address.
    assign reg_hit = (paddr[itbd_pkg::PADDR_W-1] == itbd_pkg::REG_RADIX);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? itbd_pkg::APB_DW'(r_radix) : '0;

    // Radix register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itbd_pkg::RADIX_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_radix <= pwdata[itbd_pkg::RADIX_W-1:0];
        end
    end

    // Accept a transaction whenever the queue has room.
    assign i_in_ch.ready = !i_q_full;
    assign o_push        = i_in_ch.valid && !i_q_full;
    assign o_push_value  = i_in_ch.value;
    assign o_push_radix  = itbd_pkg::effective_radix(r_radix);

endmodule

`default_nettype wire

>>> sv/itbd_queue.sv
// ----------------------------------------------------------------------------
// Integer to base digits: work queue
// Short FIFO between the front end and the conversion back end.
// ----------------------------------------------------------------------------
`default_nettype none

module itbd_queue #(
    parameter int W = itbd_pkg::VALUE_WIDTH_DEF + itbd_pkg::RADIX_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    input  logic         i_pop,
    output logic         o_valid,
    output logic         o_full,
    output logic [W-1:0] o_rdata
);

    localparam int DEPTH = itbd_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

>>> sv/itbd_back.sv
// ----------------------------------------------------------------------------
// Integer to base digits: conversion back end
// Divides the value by the radix a few quotient bits per cycle, stores the
// remainders in the digit buffer and replays them most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module itbd_back #(
    parameter int VALUE_WIDTH = itbd_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = itbd_pkg::MAX_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  logic [VALUE_WIDTH-1:0]       i_q_value,
    input  logic [itbd_pkg::RADIX_W-1:0] i_q_radix,
    output logic                         o_pop,
    itbd_out_if.source                   o_out_ch,
    output itbd_pkg::t_back_status       o_status
);

    localparam int RW         = itbd_pkg::RADIX_W;
    localparam int STEP       = itbd_pkg::DIV_BITS_PER_CYCLE;
    localparam int DIV_CYCLES = (VALUE_WIDTH + STEP - 1) / STEP;
    localparam int PAD_W      = DIV_CYCLES * STEP;
    localparam int SW         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int AW         = $clog2(MAX_DIGITS);
    localparam int CW         = $clog2(MAX_DIGITS + 1);

    itbd_pkg::t_back_state r_state;
    itbd_pkg::t_back_state n_state;

    logic [PAD_W-1:0] r_quot;
    logic [PAD_W-1:0] n_quot;
    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    n_rem;
    logic [RW:0]      div_tmp;
    logic [RW-1:0]    r_radix;
    logic [SW-1:0]    r_step;
    logic [CW-1:0]    r_digit_count;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    idx_dec;
    logic [RW-1:0]    r_buf [MAX_DIGITS];
    logic [RW-1:0]    r_rd_data;
    logic             r_out_valid;
    logic             r_out_last;
    logic             load;
    logic             digit_done;
    logic             conv_end;
    logic             issue;

    // Restoring division: STEP quotient bits per cycle, remainder below radix.
    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        div_tmp = '0;
        for (int i = 0; i < STEP; i++) begin
            div_tmp = {n_rem, n_quot[PAD_W-1]};
            n_quot  = {n_quot[PAD_W-2:0], 1'b0};
            if (div_tmp >= {1'b0, r_radix}) begin
                n_rem     = RW'(div_tmp - {1'b0, r_radix});
                n_quot[0] = 1'b1;
            end else begin
                n_rem = div_tmp[RW-1:0];
            end
        end
    end

    // Sequencer events.
    assign load       = (r_state == itbd_pkg::ST_IDLE) && i_q_valid;
    assign digit_done = (r_state == itbd_pkg::ST_DIV) && (r_step == SW'(DIV_CYCLES - 1));
    assign conv_end   = digit_done
                        && ((n_quot == '0) || (r_digit_count == CW'(MAX_DIGITS - 1)));
    assign issue      = (r_state == itbd_pkg::ST_EMIT) && (!r_out_valid || o_out_ch.ready);
    assign idx_dec    = r_idx - CW'(1);
    assign o_pop      = load;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itbd_pkg::ST_IDLE: begin
                if (load) begin
                    n_state = itbd_pkg::ST_DIV;
                end
            end
            itbd_pkg::ST_DIV: begin
                if (conv_end) begin
                    n_state = itbd_pkg::ST_EMIT;
                end
            end
            itbd_pkg::ST_EMIT: begin
                if (issue && (r_idx == CW'(1))) begin
                    n_state = itbd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itbd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= itbd_pkg::ST_IDLE;
            r_step        <= '0;
            r_digit_count <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_step        <= '0;
                r_digit_count <= '0;
            end else if (r_state == itbd_pkg::ST_DIV) begin
                r_step <= digit_done ? '0 : r_step + SW'(1);
                if (digit_done) begin
                    r_digit_count <= r_digit_count + CW'(1);
                end
            end
            if (conv_end) begin
                r_idx <= r_digit_count + CW'(1);
            end else if (issue) begin
                r_idx <= idx_dec;
            end
            if (issue) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_quot  <= PAD_W'(i_q_value);
            r_rem   <= '0;
            r_radix <= i_q_radix;
        end else if (r_state == itbd_pkg::ST_DIV) begin
            r_quot <= n_quot;
            r_rem  <= digit_done ? '0 : n_rem;
        end
        if (issue) begin
            r_out_last <= (r_idx == CW'(1));
        end
    end

    // Digit buffer: written with each remainder, read in reverse order.
    always_ff @(posedge i_clk) begin
        if (digit_done) begin
            r_buf[r_digit_count[AW-1:0]] <= n_rem;
        end
        if (issue) begin
            r_rd_data <= r_buf[idx_dec[AW-1:0]];
        end
    end

    // Output transaction.
    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.digit_char = itbd_pkg::digit_to_ascii(r_rd_data);
    assign o_out_ch.last       = r_out_last;

    assign o_status.idle     = (r_state == itbd_pkg::ST_IDLE);
    assign o_status.emitting = (r_state == itbd_pkg::ST_EMIT);

endmodule

`default_nettype wire

>>> sv/integer_to_base_digits.sv
// ----------------------------------------------------------------------------
// Integer to base digits
// Converts an unsigned value to ASCII digits in a programmable radix,
// most significant digit first, with the final digit flagged.
// ----------------------------------------------------------------------------
//  Channel    Direction  Contents
//  i_in_ch    in         value
//  o_out_ch   out        digit_char, last
//  APB        in/out     radix register at byte address 0
//
//  Each value is loaded into the divider, then divided once per digit at 8
//  quotient bits per cycle over the 32-bit padded value; the digits are then
//  replayed out most significant first.
//  A two-entry queue takes new transactions while a conversion runs.
//  Synchronous active-low reset; the radix returns to ten.
//  A stalled output holds the buffer read, and the next value is not loaded
//  into the divider until the replay of the current one has ended.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_base_digits_defines.svh"

module integer_to_base_digits #(
    parameter int VALUE_WIDTH = itbd_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_DIGITS  = itbd_pkg::MAX_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    itbd_in_if.sink                      i_in_ch,
    itbd_out_if.source                   o_out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [itbd_pkg::PADDR_W-1:0] paddr,
    input  logic [itbd_pkg::APB_DW-1:0]  pwdata,
    output logic [itbd_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    localparam int RW = itbd_pkg::RADIX_W;
    localparam int QW = VALUE_WIDTH + RW;

    logic                   push;
    logic [VALUE_WIDTH-1:0] push_value;
    logic [RW-1:0]          push_radix;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    logic [QW-1:0]          q_rdata;
    logic [VALUE_WIDTH-1:0] q_value;
    logic [RW-1:0]          q_radix;
    itbd_pkg::t_back_status back_stat;

    // Front end: register port and input acceptance.
    itbd_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (i_in_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_value (push_value),
        .o_push_radix (push_radix)
    );

    // Work queue between the two halves.
    itbd_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({push_value, push_radix}),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_rdata (q_rdata)
    );

    assign q_value = q_rdata[QW-1:RW];
    assign q_radix = q_rdata[RW-1:0];

    // Back end: division and digit replay.
    itbd_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_value (q_value),
        .i_q_radix (q_radix),
        .o_pop     (q_pop),
        .o_out_ch  (o_out_ch),
        .o_status  (back_stat)
    );

    // Queued work always carries a radix already clamped into range.
    `ITBD_ASSERT(a_queued_radix_in_range, i_clk, i_rst_n,
        q_valid |-> (q_radix >= itbd_pkg::RADIX_MIN && q_radix <= itbd_pkg::RADIX_MAX))

    // A new output transaction only appears out of the replay phase.
    `ITBD_ASSERT(a_output_from_replay, i_clk, i_rst_n,
        $rose(o_out_ch.valid) |-> $past(back_stat.emitting))

    // Reset leaves the back end idle with no output pending.
    `ITBD_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (back_stat.idle && !o_out_ch.valid))

endmodule

`default_nettype wire
